/* src/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every rising clock edge outside reset.
`define ASSERT_ON(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Precondition in one cycle implies the postcondition in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ON(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

/* src/lkvc_pkg.sv */
// Shared types and constants of the LRU key/value cache.
package lkvc_pkg;

    localparam int CAP_W  = 5;
    localparam int DATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;
    localparam logic signed [DATA_W-1:0] PUT_VALUE  = 32'sd0;

    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
    } t_result;

endpackage

/* src/lkvc_lookup.sv */
// Parallel key match, LRU slot search and first free slot search.
module lkvc_lookup #(
    parameter int N  = 16,
    parameter int IW = (N > 1) ? $clog2(N) : 1,
    parameter int CW = $clog2(N + 1)
) (
    input  logic [lkvc_pkg::DATA_W-1:0] i_keys [N],
    input  logic [N-1:0]                i_valid,
    input  logic [IW-1:0]               i_ranks [N],
    input  logic [CW-1:0]               i_count,
    input  logic [lkvc_pkg::DATA_W-1:0] i_key,
    output logic                        o_hit,
    output logic [IW-1:0]               o_hit_idx,
    output logic [IW-1:0]               o_lru_idx,
    output logic                        o_free_vld,
    output logic [IW-1:0]               o_free_idx
);

    logic [N-1:0]  match_oh;
    logic [N-1:0]  lru_oh;
    logic [N-1:0]  free_oh;
    logic [N-1:0]  invalid;
    logic [CW-1:0] last_rank;

    // valid entries hold distinct ranks 0..count-1, so the LRU one has rank count-1
    assign last_rank = i_count - CW'(1);
    assign invalid   = ~i_valid;
    assign free_oh   = invalid & (~invalid + N'(1));

    always_comb begin
        for (int i = 0; i < N; i++) begin
            match_oh[i] = i_valid[i] && (i_keys[i] == i_key);
            lru_oh[i]   = i_valid[i] && (i_ranks[i] == last_rank[IW-1:0]);
        end
    end

    // keys are unique among valid entries and ranks are distinct: each vector has at most one bit set
    always_comb begin
        o_hit_idx  = '0;
        o_lru_idx  = '0;
        o_free_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (match_oh[i]) o_hit_idx  = o_hit_idx | IW'(i);
            if (lru_oh[i])   o_lru_idx  = o_lru_idx | IW'(i);
            if (free_oh[i])  o_free_idx = o_free_idx | IW'(i);
        end
    end

    assign o_hit      = |match_oh;
    assign o_free_vld = |invalid;

endmodule

/* src/lkvc_store.sv */
// Entry storage, recency ranks and the registered get/put update.
module lkvc_store #(
    parameter int N = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  lkvc_pkg::t_req             i_req,
    input  logic [lkvc_pkg::CAP_W-1:0] i_cap,
    output lkvc_pkg::t_result          o_res
);

    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int CW = $clog2(N + 1);
    localparam int EW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;

    logic [lkvc_pkg::DATA_W-1:0] r_keys  [N];
    logic [lkvc_pkg::DATA_W-1:0] r_vals  [N];
    logic [IW-1:0]               r_ranks [N];
    logic [IW-1:0]               n_ranks [N];
    logic [N-1:0]                r_valid;
    logic [N-1:0]                n_valid;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;

    logic          hit;
    logic [IW-1:0] hit_idx;
    logic [IW-1:0] lru_idx;
    logic          free_vld;
    logic [IW-1:0] free_idx;

    logic [EW-1:0] cap_ext;
    logic [EW-1:0] eff_cap;
    logic          room;
    logic          is_put;
    logic          do_insert;
    logic          do_evict;
    logic          touch;
    logic [IW-1:0] sel_idx;
    logic [IW-1:0] tgt_idx;
    logic [IW-1:0] thr;

    lkvc_lookup #(
        .N (N)
    ) u_lookup (
        .i_keys     (r_keys),
        .i_valid    (r_valid),
        .i_ranks    (r_ranks),
        .i_count    (r_count),
        .i_key      (i_req.key),
        .o_hit      (hit),
        .o_hit_idx  (hit_idx),
        .o_lru_idx  (lru_idx),
        .o_free_vld (free_vld),
        .o_free_idx (free_idx)
    );

    // zero capacity acts as one, capacity above the store saturates
    always_comb begin
        cap_ext = EW'(i_cap);
        if (cap_ext == '0) begin
            eff_cap = EW'(1);
        end else if (cap_ext > EW'(N)) begin
            eff_cap = EW'(N);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign room      = EW'(r_count) < eff_cap;
    assign is_put    = (i_req.func == lkvc_pkg::FUNC_PUT);
    assign do_insert = i_vld && is_put && !hit && room && free_vld;
    assign do_evict  = i_vld && is_put && !hit && !do_insert;
    assign touch     = i_vld && (hit || is_put);
    assign sel_idx   = hit ? hit_idx : lru_idx;
    assign tgt_idx   = do_insert ? free_idx : sel_idx;
    assign thr       = r_ranks[sel_idx];

    // touched slot goes to rank 0; an insert ages every other valid entry, otherwise only the more recent
    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        for (int i = 0; i < N; i++) begin
            n_ranks[i] = r_ranks[i];
            if (touch) begin
                if (IW'(i) == tgt_idx) begin
                    n_ranks[i] = '0;
                end else if (r_valid[i] && (do_insert || (r_ranks[i] < thr))) begin
                    n_ranks[i] = r_ranks[i] + IW'(1);
                end
            end
        end
        if (do_insert) begin
            n_valid[free_idx] = 1'b1;
            n_count           = r_count + CW'(1);
        end
    end

    always_comb begin
        o_res.hit     = hit;
        o_res.evicted = do_evict;
        if (is_put) begin
            o_res.read_value = lkvc_pkg::PUT_VALUE;
        end else if (hit) begin
            o_res.read_value = r_vals[hit_idx];
        end else begin
            o_res.read_value = lkvc_pkg::MISS_VALUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < N; i++) begin
                r_ranks[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            r_ranks <= n_ranks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_insert || do_evict) begin
            r_keys[tgt_idx] <= i_req.key;
        end
        if (i_vld && is_put) begin
            r_vals[tgt_idx] <= i_req.value;
        end
    end

endmodule

/* src/lru_key_value_cache_unit.sv */
// Top level of the LRU key/value cache: request, result and capacity registers.
//
//  Channel   Handshake                 Payload
//  request   i_start / o_busy          i_func, i_lookup_key, i_store_value
//  result    o_done (strobe)           o_hit, o_read_value, o_evicted
//  config    i_cfg_valid / o_cfg_ready i_cfg_data (capacity_in_use)
//
//  One request per cycle; its result strobes once the start transfer has passed
//  the input register, the parallel key match and rank update over all entries,
//  and the result register.
//  Synchronous reset invalidates all entries, clears the count and sets the capacity to 16.
//  o_busy stays low; the receiver takes every result in its strobe cycle.
//  Capacity writes are held off while a request sits in the input register.
`include "assert_macros.svh"

module lru_key_value_cache_unit #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_func,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_lookup_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_store_value,
    output logic                              o_done,
    output logic                              o_hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] o_read_value,
    output logic                              o_evicted,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0]        i_cfg_data
);

    logic                       r_in_vld;
    lkvc_pkg::t_req             r_req;
    logic                       r_out_vld;
    lkvc_pkg::t_result          r_res;
    lkvc_pkg::t_result          res;
    logic [lkvc_pkg::CAP_W-1:0] r_cap;
    logic                       accept;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = !r_in_vld;
    assign accept      = i_start && !o_busy;

    lkvc_store #(
        .N (MAX_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_req   (r_req),
        .i_cap   (r_cap),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cap     <= lkvc_pkg::CAP_RESET;
        end else begin
            r_in_vld  <= accept;
            r_out_vld <= r_in_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.func  <= i_func;
            r_req.key   <= i_lookup_key;
            r_req.value <= i_store_value;
        end
        if (r_in_vld) begin
            r_res <= res;
        end
    end

    assign o_done       = r_out_vld;
    assign o_hit        = r_out_vld && r_res.hit;
    assign o_read_value = r_res.read_value;
    assign o_evicted    = r_out_vld && r_res.evicted;

    `ASSERT_NEXT(a_req_moves_on, i_clk, i_rst_n, accept, r_in_vld, "accepted request not staged")
    `ASSERT_ON(a_evict_on_miss, i_clk, i_rst_n, o_evicted |-> (o_done && !o_hit), "eviction on hit")
    `ASSERT_ON(a_miss_value, i_clk, i_rst_n, (o_done && !o_hit && (o_read_value != lkvc_pkg::PUT_VALUE)) |-> (o_read_value == lkvc_pkg::MISS_VALUE), "bad miss value")

endmodule
